/* sv/b64d_pkg.sv */
// ----------------------------------------------------------------------------
// Base64 stream decoder package
// Shared widths, the job word passed from front to back, and the lenient
// character table.
// ----------------------------------------------------------------------------
`default_nettype none

package b64d_pkg;

    localparam int CharWidth  = 8;
    localparam int ByteWidth  = 8;
    localparam int SextWidth  = 6;
    localparam int GroupWidth = 24;
    localparam int AccWidth   = 18;
    localparam int QueueDepth = 4;
    localparam int QueueAddrWidth = $clog2(QueueDepth);

    localparam logic [CharWidth-1:0] PadChar = 8'h3D;

    localparam logic [1:0] PosFirst  = 2'd0;
    localparam logic [1:0] PosSecond = 2'd1;
    localparam logic [1:0] PosThird  = 2'd2;
    localparam logic [1:0] PosFourth = 2'd3;

    typedef struct packed {
        logic [GroupWidth-1:0] word;
        logic [1:0]            count;
        logic                  final_group;
    } b64d_job_t;

    function automatic logic [SextWidth-1:0] sextet_of(input logic [CharWidth-1:0] c);
        logic [SextWidth-1:0] v;
        v = '0;
        if (c inside {[8'h41:8'h5A]})
        begin
            v = SextWidth'(c - 8'h41);
        end
        else if (c inside {[8'h61:8'h7A]})
        begin
            v = SextWidth'(c - 8'h61 + 8'd26);
        end
        else if (c inside {[8'h30:8'h39]})
        begin
            v = SextWidth'(c - 8'h30 + 8'd52);
        end
        else if (c inside {8'h2B, 8'h2D, 8'h2E})
        begin
            v = 6'd62;
        end
        else if (c inside {8'h2F, 8'h2C, 8'h5F})
        begin
            v = 6'd63;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

/* sv/b64d_if.sv */
// ----------------------------------------------------------------------------
// Base64 stream decoder channels
// Valid/ready channels for text characters in and decoded bytes out.
// ----------------------------------------------------------------------------
`default_nettype none

interface b64d_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       is_final;

    modport source (output valid, output char_in, output is_final, input ready);
    modport sink   (input valid, input char_in, input is_final, output ready);
endinterface

interface b64d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic       end_of_data;

    modport source (output valid, output byte_out, output end_of_data, input ready);
    modport sink   (input valid, input byte_out, input end_of_data, output ready);
endinterface

`default_nettype wire

/* sv/base64_stream_decoder_unit.sv */
// ----------------------------------------------------------------------------
// Base64 stream decoder
// Lenient base64 decoder: one text character in per word, decoded bytes out
// one per word. Both the standard and the URL alphabet are accepted; '+', '-'
// and '.' decode as 62, '/', ',' and '_' as 63, and any other character as 0.
// A character flagged as final closes the text and produces a short tail,
// whose last byte carries end_of_data. A character is accepted every cycle
// while the four-entry job queue has room; the back end sends one byte per
// cycle while the output is taken, and the sustained rate is then one
// character per cycle. A group's job passes through the job queue, the back
// end's word register and its output register before its first byte shows.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_decoder_unit
    import b64d_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    b64d_char_if.sink   in_ch,
    b64d_byte_if.source out_ch
);

    logic      push;
    logic      pop;
    logic      queue_full;
    logic      queue_not_empty;
    b64d_job_t push_job;
    b64d_job_t head_job;

    b64d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .queue_full (queue_full),
        .push       (push),
        .job        (push_job)
    );

    b64d_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head_job  (head_job)
    );

    b64d_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (queue_not_empty),
        .job       (head_job),
        .pop       (pop),
        .out_ch    (out_ch)
    );

endmodule

`default_nettype wire

/* sv/b64d_front.sv */
// ----------------------------------------------------------------------------
// Base64 decoder front end
// Accepts characters, gathers sextets into groups and hands each completed
// group or final tail to the job queue as a word with a byte count.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_front
    import b64d_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    b64d_char_if.sink  in_ch,
    input  wire logic  queue_full,
    output logic       push,
    output b64d_job_t  job
);

    logic [1:0]          pos_reg, pos_next;
    logic [AccWidth-1:0] acc_reg, acc_next;
    logic                pad3_reg, pad3_next;

    logic                 accept;
    logic [SextWidth-1:0] v;
    logic                 is_pad;
    logic [GroupWidth-1:0] full_word;

    assign in_ch.ready = !queue_full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign v           = sextet_of(in_ch.char_in);
    assign is_pad      = (in_ch.char_in == PadChar);
    assign full_word   = {acc_reg, v};

    always_comb
    begin
        job.final_group = in_ch.is_final;
        case (pos_reg)
            PosFirst:  job.word = {v, 18'd0};
            PosSecond: job.word = {full_word[11:0], 12'd0};
            PosThird:  job.word = {full_word[17:0], 6'd0};
            default:   job.word = full_word;
        endcase

        job.count = 2'd0;
        if (in_ch.is_final)
        begin
            case (pos_reg)
                PosFirst, PosSecond: job.count = 2'd1;
                PosThird:            job.count = is_pad ? 2'd1 : 2'd2;
                default:             job.count = !is_pad ? 2'd3 : (pad3_reg ? 2'd1 : 2'd2);
            endcase
        end
        else if (pos_reg == PosFourth)
        begin
            job.count = 2'd3;
        end
    end

    assign push = accept && (job.count != 2'd0);

    always_comb
    begin
        pos_next  = pos_reg;
        acc_next  = acc_reg;
        pad3_next = pad3_reg;
        if (accept)
        begin
            if (in_ch.is_final || pos_reg == PosFourth)
            begin
                pos_next  = PosFirst;
                acc_next  = '0;
                pad3_next = 1'b0;
            end
            else
            begin
                if (pos_reg == PosThird)
                begin
                    pad3_next = is_pad;
                end
                acc_next = {acc_reg[AccWidth-SextWidth-1:0], v};
                pos_next = pos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= PosFirst;
            acc_reg  <= '0;
            pad3_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            acc_reg  <= acc_next;
            pad3_reg <= pad3_next;
        end
    end

endmodule

`default_nettype wire

/* sv/b64d_queue.sv */
// ----------------------------------------------------------------------------
// Base64 decoder job queue
// Small first-in first-out store of group jobs between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_queue
    import b64d_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire b64d_job_t push_job,
    input  wire logic      pop,
    output logic           full,
    output logic           not_empty,
    output b64d_job_t      head_job
);

    b64d_job_t                 entry_reg [QueueDepth];
    logic [QueueAddrWidth-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QueueAddrWidth-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QueueAddrWidth:0]   fill_reg, fill_next;

    assign full      = (fill_reg == (QueueAddrWidth+1)'(QueueDepth));
    assign not_empty = (fill_reg != '0);
    assign head_job  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

`default_nettype wire

/* sv/b64d_back.sv */
// ----------------------------------------------------------------------------
// Base64 decoder back end
// Takes jobs from the queue and sends their bytes out one per cycle while the
// output is taken, high byte first, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_back
    import b64d_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      job_valid,
    input  wire b64d_job_t job,
    output logic           pop,
    b64d_byte_if.source    out_ch
);

    logic                  busy_reg, busy_next;
    logic [GroupWidth-1:0] word_reg, word_next;
    logic [1:0]            left_reg, left_next;
    logic                  final_reg, final_next;
    logic                  out_valid_reg, out_valid_next;
    logic [ByteWidth-1:0]  out_byte_reg, out_byte_next;
    logic                  out_end_reg, out_end_next;

    logic slot_free;
    logic emit;
    logic last;

    assign slot_free = !out_valid_reg || out_ch.ready;
    assign emit      = busy_reg && slot_free;
    assign last      = emit && (left_reg == 2'd1);
    assign pop       = job_valid && (!busy_reg || last);

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.byte_out    = out_byte_reg;
    assign out_ch.end_of_data = out_end_reg;

    always_comb
    begin
        busy_next      = busy_reg;
        word_next      = word_reg;
        left_next      = left_reg;
        final_next     = final_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_end_next   = out_end_reg;

        if (pop)
        begin
            busy_next  = 1'b1;
            word_next  = job.word;
            left_next  = job.count;
            final_next = job.final_group;
        end
        else if (emit)
        begin
            busy_next = !last;
            word_next = {word_reg[GroupWidth-ByteWidth-1:0], {ByteWidth{1'b0}}};
            left_next = left_reg - 2'd1;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = word_reg[GroupWidth-1 -: ByteWidth];
            out_end_next   = final_reg && (left_reg == 2'd1);
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg     <= word_next;
        left_reg     <= left_next;
        final_reg    <= final_next;
        out_byte_reg <= out_byte_next;
        out_end_reg  <= out_end_next;
    end

endmodule

`default_nettype wire

/* tb/base64_stream_decoder_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 stream decoder testbench
// Sends text characters into the decoder and checks each decoded byte against
// an independent model of the lenient decoding table and of the tail rules.
// A short table of directed characters comes first. Random texts follow,
// mostly well formed and partly noise. Both channels idle at random, and the
// output is held off for a long stretch so that the decoder stalls its input.
// ----------------------------------------------------------------------------

module base64_stream_decoder_unit_tb
    import b64d_pkg::*;
();

    typedef struct packed {
        logic [7:0]  data;
        logic        eod;
    } decoded_byte_t;

    typedef struct packed {
        logic [7:0]  ch;
        logic        fin;
        logic        typed;
        logic [1:0]  typed_n;
        logic [23:0] typed_word;
    } stim_row_t;

    localparam int DirectedCount = 25;

    // Rows with typed set carry their decoded bytes here; the others rely on the model.
    localparam stim_row_t DirectedRows [DirectedCount] = '{
        '{"A",   1'b0, 1'b0, 2'd0, 24'h000000},
        '{"A",   1'b0, 1'b0, 2'd0, 24'h000000},
        '{"A",   1'b0, 1'b0, 2'd0, 24'h000000},
        '{"A",   1'b0, 1'b1, 2'd3, 24'h000000},
        '{"+",   1'b0, 1'b0, 2'd0, 24'h000000},
        '{"-",   1'b0, 1'b0, 2'd0, 24'h000000},
        '{".",   1'b0, 1'b0, 2'd0, 24'h000000},
        '{"/",   1'b1, 1'b0, 2'd0, 24'h000000},
        '{"Z",   1'b0, 1'b0, 2'd0, 24'h000000},
        '{"_",   1'b0, 1'b0, 2'd0, 24'h000000},
        '{",",   1'b1, 1'b0, 2'd0, 24'h000000},
        '{"a",   1'b0, 1'b0, 2'd0, 24'h000000},
        '{"z",   1'b0, 1'b0, 2'd0, 24'h000000},
        '{"=",   1'b0, 1'b0, 2'd0, 24'h000000},
        '{"=",   1'b1, 1'b0, 2'd0, 24'h000000},
        '{8'hFF, 1'b1, 1'b1, 2'd1, 24'h000000},
        '{8'h00, 1'b0, 1'b0, 2'd0, 24'h000000},
        '{"W",   1'b1, 1'b0, 2'd0, 24'h000000},
        '{"T",   1'b0, 1'b0, 2'd0, 24'h000000},
        '{"W",   1'b0, 1'b0, 2'd0, 24'h000000},
        '{"=",   1'b1, 1'b0, 2'd0, 24'h000000},
        '{"0",   1'b0, 1'b0, 2'd0, 24'h000000},
        '{"9",   1'b0, 1'b0, 2'd0, 24'h000000},
        '{"F",   1'b0, 1'b0, 2'd0, 24'h000000},
        '{"=",   1'b1, 1'b0, 2'd0, 24'h000000}
    };

    logic clk;
    logic rst_n;

    b64d_char_if char_bus ();
    b64d_byte_if byte_bus ();

    base64_stream_decoder_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (char_bus),
        .out_ch (byte_bus)
    );

    decoded_byte_t byte_expect_q [$];
    decoded_byte_t head_byte;
    int            mismatch_count;
    int            chars_sent;
    bit            steady_run;
    bit            hold_req;
    int            hold_left;

    logic [1:0]    grp_pos;
    logic [17:0]   grp_acc;
    logic          grp_third_pad;

    always #5 clk = ~clk;

    function automatic logic [5:0] sextet_value(input logic [7:0] c);
        logic [5:0] v;
        v = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            v = 6'(c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            v = 6'(c - 8'h61 + 8'd26);
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            v = 6'(c - 8'h30 + 8'd52);
        end
        else if (c == "+" || c == "-" || c == ".")
        begin
            v = 6'd62;
        end
        else if (c == "/" || c == "," || c == "_")
        begin
            v = 6'd63;
        end
        return v;
    endfunction

    function automatic logic [7:0] alphabet_char();
        int v;
        int pick;
        v = $urandom_range(63);
        pick = $urandom_range(2);
        if (v < 26)
        begin
            return 8'(8'h41 + v);
        end
        else if (v < 52)
        begin
            return 8'(8'h61 + v - 26);
        end
        else if (v < 62)
        begin
            return 8'(8'h30 + v - 52);
        end
        else if (v == 62)
        begin
            return (pick == 0) ? "+" : (pick == 1) ? "-" : ".";
        end
        return (pick == 0) ? "/" : (pick == 1) ? "," : "_";
    endfunction

    task automatic decode_char(input logic [7:0] c, input logic fin,
                               output int n, output logic [23:0] group_word);
        logic [5:0] v;
        logic       is_pad;
        int         shift;
        v = sextet_value(c);
        is_pad = (c == PadChar);
        shift = 6 * (3 - int'(grp_pos));
        group_word = {grp_acc, v} << shift;
        n = 0;
        if (fin)
        begin
            if (grp_pos == PosFirst || grp_pos == PosSecond)
            begin
                n = 1;
            end
            else if (grp_pos == PosThird)
            begin
                n = is_pad ? 1 : 2;
            end
            else if (!is_pad)
            begin
                n = 3;
            end
            else
            begin
                n = grp_third_pad ? 1 : 2;
            end
        end
        else if (grp_pos == PosFourth)
        begin
            n = 3;
        end
        if (fin || grp_pos == PosFourth)
        begin
            grp_pos = PosFirst;
            grp_acc = '0;
            grp_third_pad = 1'b0;
        end
        else
        begin
            if (grp_pos == PosThird)
            begin
                grp_third_pad = is_pad;
            end
            grp_acc = {grp_acc[11:0], v};
            grp_pos = grp_pos + 2'd1;
        end
    endtask

    task automatic send_char(input logic [7:0] c, input logic fin, input logic typed,
                             input logic [1:0] typed_n, input logic [23:0] typed_word);
        int            n;
        logic [23:0]   group_word;
        decoded_byte_t item;
        while (!steady_run && $urandom_range(99) < 35)
        begin
            char_bus.valid <= 1'b0;
            @(posedge clk);
        end
        char_bus.valid    <= 1'b1;
        char_bus.char_in  <= c;
        char_bus.is_final <= fin;
        @(posedge clk);
        while (!char_bus.ready)
        begin
            @(posedge clk);
        end
        decode_char(c, fin, n, group_word);
        if (typed)
        begin
            n = typed_n;
            group_word = typed_word;
        end
        for (int k = 0; k < n; k++)
        begin
            item.data = group_word[23 - 8 * k -: 8];
            item.eod  = fin && (k == n - 1);
            byte_expect_q = {byte_expect_q, item};
        end
        chars_sent++;
    endtask

    task automatic send_text();
        logic [7:0] tail_chars [4];
        int         tail_len;
        int         groups;
        int         tail_kind;
        int         noise_len;
        if ($urandom_range(99) < 75)
        begin
            groups = $urandom_range(3);
            tail_kind = $urandom_range(5);
            if (groups == 0 && tail_kind == 0)
            begin
                tail_kind = 1;
            end
            for (int g = 0; g < groups; g++)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    send_char(alphabet_char(), tail_kind == 0 && g == groups - 1 && i == 3,
                              1'b0, 2'd0, 24'h0);
                end
            end
            tail_len = 0;
            case (tail_kind)
                1: tail_len = 1;
                2: tail_len = 2;
                3: tail_len = 3;
                4: tail_len = 4;
                5: tail_len = 4;
                default: tail_len = 0;
            endcase
            for (int i = 0; i < 4; i++)
            begin
                tail_chars[i] = alphabet_char();
            end
            if (tail_kind == 4)
            begin
                tail_chars[2] = PadChar;
                tail_chars[3] = PadChar;
            end
            else if (tail_kind == 5)
            begin
                tail_chars[3] = PadChar;
            end
            for (int i = 0; i < tail_len; i++)
            begin
                send_char(tail_chars[i], i == tail_len - 1, 1'b0, 2'd0, 24'h0);
            end
        end
        else
        begin
            noise_len = $urandom_range(8, 1);
            for (int i = 0; i < noise_len; i++)
            begin
                send_char(($urandom_range(9) == 0) ? PadChar : 8'($urandom_range(255)),
                          $urandom_range(3) == 0, 1'b0, 2'd0, 24'h0);
            end
        end
    endtask

    task automatic wait_for_bytes();
        char_bus.valid <= 1'b0;
        @(posedge clk);
        while (byte_expect_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && byte_bus.valid && byte_bus.ready)
        begin
            if (byte_expect_q.size() == 0)
            begin
                $error("byte_out: expected none, got %02h", byte_bus.byte_out);
                mismatch_count++;
            end
            else
            begin
                head_byte = byte_expect_q.pop_front();
                if (byte_bus.byte_out !== head_byte.data)
                begin
                    $error("byte_out: expected %02h, got %02h",
                           head_byte.data, byte_bus.byte_out);
                    mismatch_count++;
                end
                if (byte_bus.end_of_data !== head_byte.eod)
                begin
                    $error("end_of_data: expected %0b, got %0b",
                           head_byte.eod, byte_bus.end_of_data);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        byte_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = 60;
            end
            if (hold_left > 0)
            begin
                byte_bus.ready <= 1'b0;
                hold_left--;
            end
            else if (steady_run)
            begin
                byte_bus.ready <= 1'b1;
            end
            else
            begin
                byte_bus.ready <= ($urandom_range(99) >= 35);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("base64_stream_decoder_unit_tb: errors");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n <= 1'b0;
        char_bus.valid    <= 1'b0;
        char_bus.char_in  <= 8'h00;
        char_bus.is_final <= 1'b0;
        mismatch_count = 0;
        chars_sent = 0;
        steady_run = 1'b0;
        hold_req = 1'b0;
        hold_left = 0;
        grp_pos = PosFirst;
        grp_acc = '0;
        grp_third_pad = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DirectedCount; i++)
        begin
            send_char(DirectedRows[i].ch, DirectedRows[i].fin, DirectedRows[i].typed,
                      DirectedRows[i].typed_n, DirectedRows[i].typed_word);
        end
        wait_for_bytes();

        while (chars_sent < 100)
        begin
            send_text();
        end

        // The output stalls while characters keep coming, so the job queue fills up.
        steady_run = 1'b1;
        hold_req = 1'b1;
        while (chars_sent < 170)
        begin
            send_text();
        end
        steady_run = 1'b0;
        wait_for_bytes();

        while (chars_sent < 255)
        begin
            send_text();
        end
        wait_for_bytes();
        repeat (10) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("base64_stream_decoder_unit_tb: clean");
        end
        else
        begin
            $display("base64_stream_decoder_unit_tb: errors");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/b64d_pkg.sv
sv/b64d_if.sv
sv/b64d_front.sv
sv/b64d_queue.sv
sv/b64d_back.sv
sv/base64_stream_decoder_unit.sv
tb/base64_stream_decoder_unit_tb.sv
